### src/r250_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// R250 generator package
// Table geometry, tap and fix-up constants, and shared types.
// ----------------------------------------------------------------------------
package r250_pkg;

   localparam int TABLE_LEN     = 250;
   localparam int TAP_DIST      = 103;
   localparam int FIX_START     = 3;
   localparam int FIX_STEP      = 11;
   localparam int WORD_BITS_DEF = 32;
   localparam int MAX_WORD_BITS = 64;
   localparam int SEED_BITS     = 32;
   localparam int RESULT_BITS   = 32;
   localparam int INDEX_BITS    = 8;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // Per-cycle control shared by every cell of the ring.
   typedef struct packed {
      logic shift;
      logic fix;
   } cell_ctl_type;

   // Fix-up bit for table position pos, or -1 when the position has none.
   function automatic int fix_bit_of(input int pos, input int word_bits);
      int k;
      int result;
      result = -1;
      for (k = 0; k < word_bits; k++) begin
         if (((FIX_START + FIX_STEP * k) % TABLE_LEN) == pos) begin
            result = k;
         end
      end
      return result;
   endfunction

endpackage
`default_nettype wire

### src/r250_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// R250 table cell
// One table word; takes its neighbor's word on shift and applies its
// independence fix-up on the final load of a seeding pass.
// ----------------------------------------------------------------------------
module r250_cell #(
   parameter int WORD_BITS = r250_pkg::WORD_BITS_DEF,
   parameter int FIX_BIT   = -1
) (
   input  wire                       clock,
   input  wire r250_pkg::cell_ctl_type ctl,
   input  wire logic [WORD_BITS-1:0] shift_in,
   output logic      [WORD_BITS-1:0] word_out
);

   localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   generate
      if (FIX_BIT >= 0) begin : g_fix
         localparam logic [WORD_BITS-1:0] SET_MASK  = ONE << FIX_BIT;
         localparam logic [WORD_BITS-1:0] KEEP_MASK = ~(SET_MASK - ONE);
         always_comb begin
            word_in = shift_in;
            if (ctl.fix) begin
               word_in = (shift_in & KEEP_MASK) | SET_MASK;
            end
         end
      end else begin : g_plain
         assign word_in = shift_in;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule
`default_nettype wire

### src/r250_random_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// R250 random generator
// Lagged-XOR word generator over a 250-word ring of cells.
// ----------------------------------------------------------------------------
// Takes one request every cycle; busy is never asserted. A load (command 0)
// shifts a seed word into the ring; the 250th load applies the fix-up and
// makes the table ready. A draw (command 1) on a ready table XORs the head
// word with the word 103 places on, shifts the ring by one and drives the
// result on rsp_random_word with rsp_valid for one cycle, in the cycle after
// the request. A draw before the table is ready gives no response. The receiver
// cannot stall; every response must be taken in the cycle it is shown.
module r250_random_generator #(
   parameter int WORD_BITS = r250_pkg::WORD_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire                                   req_command,
   input  wire logic [r250_pkg::SEED_BITS-1:0]   req_seed_word,
   output logic                                  rsp_valid,
   output logic      [r250_pkg::RESULT_BITS-1:0] rsp_random_word
);

   localparam int LEN = r250_pkg::TABLE_LEN;
   localparam int IW  = r250_pkg::INDEX_BITS;
   localparam int XW  = r250_pkg::MAX_WORD_BITS;

   logic [WORD_BITS-1:0] words [LEN];
   logic [WORD_BITS-1:0] tail_in;
   logic [WORD_BITS-1:0] draw_word;
   logic [XW-1:0]        seed_ext;
   logic [XW-1:0]        draw_ext;

   logic [IW-1:0] load_index_ff;
   logic [IW-1:0] load_index_in;
   logic          ready_ff;
   logic          ready_in;
   logic          valid_ff;
   logic          valid_in;
   logic [r250_pkg::RESULT_BITS-1:0] result_ff;

   logic accept;
   logic do_load;
   logic do_draw;
   logic last_load;

   r250_pkg::cell_ctl_type ctl;

   assign busy      = 1'b0;
   assign accept    = start & ~busy;
   assign do_load   = accept & (req_command == r250_pkg::CMD_LOAD);
   assign do_draw   = accept & (req_command == r250_pkg::CMD_DRAW) & ready_ff;
   assign last_load = do_load & (load_index_ff == IW'(LEN - 1));

   assign ctl.shift = do_load | do_draw;
   assign ctl.fix   = last_load;

   assign seed_ext  = XW'(req_seed_word);
   assign draw_word = words[0] ^ words[r250_pkg::TAP_DIST];
   assign draw_ext  = XW'(draw_word);
   assign tail_in   = do_load ? seed_ext[WORD_BITS-1:0] : draw_word;

   genvar i;
   generate
      for (i = 0; i < LEN; i++) begin : g_cell
         logic [WORD_BITS-1:0] next_word;
         if (i == LEN - 1) begin : g_tail
            assign next_word = tail_in;
         end else begin : g_body
            assign next_word = words[i+1];
         end
         r250_cell #(
            .WORD_BITS (WORD_BITS),
            .FIX_BIT   (r250_pkg::fix_bit_of(i, WORD_BITS))
         ) u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .shift_in (next_word),
            .word_out (words[i])
         );
      end
   endgenerate

   always_comb begin
      load_index_in = load_index_ff;
      ready_in      = ready_ff;
      if (do_load) begin
         ready_in = 1'b0;
         if (last_load) begin
            load_index_in = '0;
            ready_in      = 1'b1;
         end else begin
            load_index_in = load_index_ff + IW'(1);
         end
      end
   end

   assign valid_in = do_draw;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff <= '0;
         ready_ff      <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         load_index_ff <= load_index_in;
         ready_ff      <= ready_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_draw) begin
         result_ff <= draw_ext[r250_pkg::RESULT_BITS-1:0];
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_random_word = result_ff;

endmodule
`default_nettype wire

### sim/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// R250 random generator testbench
// Fills the lag table with seed loads and checks every drawn word against an
// in-bench model of the table, pointer and fix-up, or for typed rows a fixed word.
// Directed rows first (seed extremes, draws before ready, reseeding mid-pass,
// pointer wrap), then random seeding passes and draw runs with random request gaps.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WORD_BITS   = r250_pkg::WORD_BITS_DEF;
   localparam int SEED_BITS   = r250_pkg::SEED_BITS;
   localparam int RESULT_BITS = r250_pkg::RESULT_BITS;
   localparam int TABLE_LEN   = r250_pkg::TABLE_LEN;
   localparam int TARGET      = 1700;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic                   cmd;
      logic [SEED_BITS-1:0]   seed;
      int                     reps;
      bit                     typed;
      logic [RESULT_BITS-1:0] want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_command = r250_pkg::CMD_LOAD;
   logic [SEED_BITS-1:0]   req_seed_word = '0;
   logic                   rsp_valid;
   logic [RESULT_BITS-1:0] rsp_random_word;

   logic [WORD_BITS-1:0]   lag_words [0:TABLE_LEN-1];
   int                     draw_ptr;
   int                     fill_idx;
   bit                     seeded;

   logic [RESULT_BITS-1:0] pending_words [$];
   int                     failures = 0;
   int                     accepted_count = 0;
   int                     cycle_count = 0;
   stim_row_type           dir_rows [12];

   r250_random_generator #(.WORD_BITS(WORD_BITS)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_seed_word   (req_seed_word),
      .rsp_valid       (rsp_valid),
      .rsp_random_word (rsp_random_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("r250_random_generator verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %h", $time,
                     rsp_random_word);
            failures++;
         end else if (rsp_random_word !== pending_words[0]) begin
            $display("%0t: random_word mismatch, expected %h, got %h", $time,
                     pending_words[0], rsp_random_word);
            failures++;
            void'(pending_words.pop_front());
         end else begin
            void'(pending_words.pop_front());
         end
      end
   end

   // Advances the table model by one request; returns 1 when a word is drawn.
   function automatic bit r250_next(input logic cmd,
                                    input logic [SEED_BITS-1:0] seed,
                                    output logic [RESULT_BITS-1:0] word);
      int                   idx;
      int                   tap;
      logic [WORD_BITS-1:0] bit_k;
      logic [WORD_BITS-1:0] mixed;
      word = '0;
      if (cmd == r250_pkg::CMD_LOAD) begin
         seeded = 1'b0;
         if (fill_idx >= TABLE_LEN) begin
            fill_idx = 0;
         end
         lag_words[fill_idx] = WORD_BITS'(seed);
         fill_idx++;
         if (fill_idx >= TABLE_LEN) begin
            idx = r250_pkg::FIX_START;
            for (int k = 0; k < WORD_BITS; k++) begin
               bit_k = WORD_BITS'(1) << k;
               lag_words[idx] = (lag_words[idx] & ~(bit_k - 1'b1)) | bit_k;
               idx = (idx + r250_pkg::FIX_STEP) % TABLE_LEN;
            end
            fill_idx = 0;
            draw_ptr = 0;
            seeded = 1'b1;
         end
         return 1'b0;
      end
      if (!seeded) begin
         return 1'b0;
      end
      tap = (draw_ptr + r250_pkg::TAP_DIST) % TABLE_LEN;
      mixed = lag_words[draw_ptr] ^ lag_words[tap];
      lag_words[draw_ptr] = mixed;
      draw_ptr = (draw_ptr + 1) % TABLE_LEN;
      word = mixed[RESULT_BITS-1:0];
      return 1'b1;
   endfunction

   function automatic logic [SEED_BITS-1:0] pick_seed();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return SEED_BITS'(1) << $urandom_range(0, SEED_BITS - 1);
         3: return ~(SEED_BITS'(1) << $urandom_range(0, SEED_BITS - 1));
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap(input bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(input logic cmd, input logic [SEED_BITS-1:0] seed,
                               input bit typed, input logic [RESULT_BITS-1:0] want);
      logic [RESULT_BITS-1:0] word;
      bit                     made;
      @(negedge clock);
      start <= 1'b1;
      req_command <= cmd;
      req_seed_word <= seed;
      do @(posedge clock); while (busy);
      made = r250_next(cmd, seed, word);
      if (made) begin
         pending_words.push_back(typed ? want : word);
      end
      accepted_count++;
   endtask

   task automatic hold_off(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
         req_command <= 1'($urandom);
         req_seed_word <= $urandom;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   initial begin
      bit no_idle;
      int n;

      draw_ptr = 0;
      fill_idx = 0;
      seeded = 1'b0;
      for (int i = 0; i < TABLE_LEN; i++) begin
         lag_words[i] = '0;
      end

      // all-ones and all-zeros tables draw zero first: neither slot 0 nor 103 is fixed up
      dir_rows[0]  = '{r250_pkg::CMD_DRAW, 32'h0000_0000,   2, 1'b0, 32'h0};
      dir_rows[1]  = '{r250_pkg::CMD_LOAD, 32'hFFFF_FFFF, 250, 1'b0, 32'h0};
      dir_rows[2]  = '{r250_pkg::CMD_DRAW, 32'hFFFF_FFFF,   1, 1'b1, 32'h0000_0000};
      dir_rows[3]  = '{r250_pkg::CMD_DRAW, 32'h1234_5678, 260, 1'b0, 32'h0};
      dir_rows[4]  = '{r250_pkg::CMD_LOAD, 32'h0000_0000,   7, 1'b0, 32'h0};
      dir_rows[5]  = '{r250_pkg::CMD_DRAW, 32'hFFFF_FFFF,   2, 1'b0, 32'h0};
      dir_rows[6]  = '{r250_pkg::CMD_LOAD, 32'hAAAA_AAAA, 121, 1'b0, 32'h0};
      dir_rows[7]  = '{r250_pkg::CMD_LOAD, 32'h5555_5555, 122, 1'b0, 32'h0};
      dir_rows[8]  = '{r250_pkg::CMD_DRAW, 32'h0000_0000,  40, 1'b0, 32'h0};
      dir_rows[9]  = '{r250_pkg::CMD_LOAD, 32'h0000_0000, 250, 1'b0, 32'h0};
      dir_rows[10] = '{r250_pkg::CMD_DRAW, 32'h0000_0000,   1, 1'b1, 32'h0000_0000};
      dir_rows[11] = '{r250_pkg::CMD_DRAW, 32'h8000_0001,   5, 1'b0, 32'h0};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         no_idle = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < dir_rows[r].reps; i++) begin
            send_request(dir_rows[r].cmd, dir_rows[r].seed, dir_rows[r].typed,
                         dir_rows[r].want);
            hold_off(pick_gap(no_idle));
         end
      end
      drain();

      while (accepted_count < TARGET) begin
         no_idle = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
               n = TABLE_LEN - fill_idx;
               repeat (n) begin
                  send_request(r250_pkg::CMD_LOAD, pick_seed(), 1'b0, '0);
                  hold_off(pick_gap(no_idle));
               end
               repeat ($urandom_range(20, 300)) begin
                  send_request(r250_pkg::CMD_DRAW, $urandom, 1'b0, '0);
                  hold_off(pick_gap(no_idle));
               end
            end
            7, 8: begin
               repeat ($urandom_range(1, 60)) begin
                  send_request(r250_pkg::CMD_LOAD, pick_seed(), 1'b0, '0);
                  hold_off(pick_gap(no_idle));
               end
               repeat ($urandom_range(1, 4)) begin
                  send_request(r250_pkg::CMD_DRAW, $urandom, 1'b0, '0);
                  hold_off(pick_gap(no_idle));
               end
            end
            default: begin
               drain();
            end
         endcase
      end

      drain();
      repeat (8) @(posedge clock);
      if (pending_words.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_words.size());
         failures++;
      end
      if (failures == 0) begin
         $display("r250_random_generator verification clean");
      end else begin
         $display("r250_random_generator verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
